// File: sv/lattice_histogram_splat_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lattice histogram splat classifier
// Shared concurrent check forms, clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_HISTOGRAM_SPLAT_CLASSIFIER_UNIT_DEFINES_SVH
`define LATTICE_HISTOGRAM_SPLAT_CLASSIFIER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lattice histogram check failed");

// Consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lattice histogram check failed");

`endif

// File: sv/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Types and fixed constants shared by the lattice histogram classifier.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam int AXES = 5;

    localparam logic [1:0] ACT_BG        = 2'd0;
    localparam logic [1:0] ACT_FG        = 2'd1;
    localparam logic [1:0] ACT_QUERY     = 2'd2;
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    localparam logic REG_WEIGHT_ONE  = 1'b0;
    localparam logic REG_WEIGHT_FOUR = 1'b1;

    localparam logic [15:0] WEIGHT_ONE_RESET  = 16'd58982;
    localparam logic [15:0] WEIGHT_FOUR_RESET = 16'd42926;

    // Splat offset digit codes: digit minus two is the cell offset.
    localparam logic [1:0] DIG_MINUS_TWO = 2'd0;
    localparam logic [1:0] DIG_ZERO      = 2'd2;

    localparam logic [16:0] WEIGHT_UNITY = 17'd65536;
    localparam logic [33:0] EP_Q16       = 34'd327680;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLAT,
        ST_DRAIN,
        ST_QREAD,
        ST_QCHK,
        ST_QDIV1,
        ST_QDIV2,
        ST_QOUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic splat_issue;
        logic div_start;
        logic div_sel;
        logic res_empty;
        logic store_prob;
        logic store_conf;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic issue_last;
        logic pipe_busy;
        logic cell_empty;
        logic div_done;
        logic div_busy;
    } stat_t;

endpackage

// File: sv/lhs_div.sv
// ----------------------------------------------------------------------------
// lhs_div
// Restoring divider for the Q0.16 ratios, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [33:0] den,
    output logic        busy,
    output logic        done,
    output logic [15:0] quot
);

    logic [48:0] dividend;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] low_reg, low_next;
    logic [16:0] q_reg, q_next;
    logic [33:0] den_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    // Rounded dividend; the quotient fits 17 bits because num never exceeds den.
    assign dividend = {1'b0, num, 16'd0} + {16'd0, den[33:1]};
    assign trial    = {rem_reg, low_reg[16]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {2'd0, dividend[48:17]};
            low_next  = dividend[16:0];
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[33:0] : trial[33:0];
            low_next = {low_reg[15:0], 1'b0};
            q_next   = {q_reg[15:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg[16] ? 16'hFFFF : q_reg[15:0];

endmodule

// File: sv/lhs_dp.sv
// ----------------------------------------------------------------------------
// lhs_dp
// Datapath: cell mapping, splat weight pipeline, histogram memories, query.
// ----------------------------------------------------------------------------
module lhs_dp #(
    parameter int CELLS_PER_AXIS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  logic [1:0]        s_action,
    input  logic [15:0]       s_coord_u,
    input  logic [15:0]       s_coord_l,
    input  logic [15:0]       s_coord_g,
    input  logic [15:0]       s_coord_s,
    input  logic [15:0]       s_coord_e,
    input  lhs_pkg::cmd_t     cmd,
    output lhs_pkg::stat_t    stat,
    output logic [15:0]       m_fg_probability,
    output logic [15:0]       m_confidence,
    output logic              m_cell_empty
);

    localparam int CB    = $clog2(CELLS_PER_AXIS);
    localparam int AW    = lhs_pkg::AXES * CB;
    localparam int DEPTH = 2 ** AW;
    localparam int NW    = 2 * lhs_pkg::AXES;
    localparam int PW    = 16 + CB + 1;
    localparam int ST    = 6;
    localparam logic [PW-1:0] C_MUL     = PW'(CELLS_PER_AXIS);
    localparam logic [PW-1:0] HALF      = PW'(32768);
    localparam logic [CB:0]   LAST_CELL = (CB + 1)'(CELLS_PER_AXIS - 1);
    localparam logic [CB+1:0] TWO       = (CB + 2)'(2);
    localparam logic [CB+1:0] POS_LIMIT = (CB + 2)'(CELLS_PER_AXIS + 2);

    logic [15:0]   coord    [lhs_pkg::AXES];
    logic [PW-1:0] scaled   [lhs_pkg::AXES];
    logic [CB:0]   rnd      [lhs_pkg::AXES];
    logic [CB-1:0] cell_now [lhs_pkg::AXES];
    logic [CB-1:0] cell_reg [lhs_pkg::AXES];
    logic          hist_fg_reg;
    logic [AW-1:0] cell_addr;

    logic [15:0]   w1_reg, w4_reg;

    logic [NW-1:0] n_reg;
    logic [CB+1:0] tpos     [lhs_pkg::AXES];
    logic [CB+1:0] tpos_m2  [lhs_pkg::AXES];
    logic [AW-1:0] issue_addr;
    logic          issue_in;

    logic [ST-1:0] act_reg;
    logic [AW-1:0] addr_reg [ST];
    logic [NW-1:0] dig_reg  [ST];
    logic [16:0]   w_reg    [ST];
    logic [16:0]   w_next   [ST];
    logic [16:0]   fac      [ST];
    logic [33:0]   wprod    [ST];
    logic [1:0]    dsel     [ST];

    logic [31:0]   fg_mem [DEPTH];
    logic [31:0]   bg_mem [DEPTH];
    logic [AW-1:0] rd_addr;
    logic [31:0]   fg_rd_reg, bg_rd_reg;
    logic [32:0]   upd_sum;
    logic [31:0]   upd;
    logic [AW-1:0] clr_reg;

    logic [32:0]   sum;
    logic [31:0]   diff;
    logic [33:0]   den_conf;
    logic [31:0]   div_num;
    logic [33:0]   div_den;
    logic          div_busy, div_done;
    logic [15:0]   quot;

    logic [15:0]   prob_reg, conf_reg;
    logic          empty_reg;
    logic [15:0]   out_prob_reg, out_conf_reg;
    logic          out_empty_reg;

    assign coord[0] = s_coord_u;
    assign coord[1] = s_coord_l;
    assign coord[2] = s_coord_g;
    assign coord[3] = s_coord_s;
    assign coord[4] = s_coord_e;

    // Nearest cell, clamped to the last one.
    always_comb begin
        for (int k = 0; k < lhs_pkg::AXES; k++) begin
            scaled[k]   = {(PW - 16)'(0), coord[k]} * C_MUL + HALF;
            rnd[k]      = scaled[k][PW-1:16];
            cell_now[k] = (rnd[k] > LAST_CELL) ? LAST_CELL[CB-1:0] : rnd[k][CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int k = 0; k < lhs_pkg::AXES; k++) begin
                cell_reg[k] <= cell_now[k];
            end
            hist_fg_reg <= (s_action == lhs_pkg::ACT_FG);
        end
    end

    assign cell_addr = {cell_reg[0], cell_reg[1], cell_reg[2], cell_reg[3], cell_reg[4]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_reg <= lhs_pkg::WEIGHT_ONE_RESET;
            w4_reg <= lhs_pkg::WEIGHT_FOUR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lhs_pkg::REG_WEIGHT_ONE:  w1_reg <= cfg_wdata;
                lhs_pkg::REG_WEIGHT_FOUR: w4_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Offset counter: one base-4 digit per axis, u in the top digit.
    always_comb begin
        issue_in = 1'b1;
        for (int k = 0; k < lhs_pkg::AXES; k++) begin
            tpos[k]    = {2'd0, cell_reg[k]}
                       + {CB'(0), n_reg[2 * (lhs_pkg::AXES - 1 - k) +: 2]};
            tpos_m2[k] = tpos[k] - TWO;
            if (tpos[k] < TWO || tpos[k] >= POS_LIMIT) begin
                issue_in = 1'b0;
            end
        end
        issue_addr = {tpos_m2[0][CB-1:0], tpos_m2[1][CB-1:0], tpos_m2[2][CB-1:0],
                      tpos_m2[3][CB-1:0], tpos_m2[4][CB-1:0]};
    end

    // Weight pipeline: stage k applies the factor of axis k-1.
    always_comb begin
        w_next[0] = lhs_pkg::WEIGHT_UNITY;
        fac[0]    = lhs_pkg::WEIGHT_UNITY;
        wprod[0]  = '0;
        dsel[0]   = lhs_pkg::DIG_ZERO;
        for (int k = 1; k < ST; k++) begin
            dsel[k] = dig_reg[k-1][2 * (lhs_pkg::AXES - k) +: 2];
            if (dsel[k] == lhs_pkg::DIG_ZERO) begin
                fac[k] = lhs_pkg::WEIGHT_UNITY;
            end else if (dsel[k] == lhs_pkg::DIG_MINUS_TWO) begin
                fac[k] = {1'b0, w4_reg};
            end else begin
                fac[k] = {1'b0, w1_reg};
            end
            wprod[k]  = {17'd0, w_reg[k-1]} * {17'd0, fac[k]} + 34'd32768;
            w_next[k] = wprod[k][32:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= '0;
            n_reg   <= '0;
            clr_reg <= '0;
        end else begin
            act_reg <= {act_reg[ST-2:0], cmd.splat_issue & issue_in};
            if (cmd.capture) begin
                n_reg <= '0;
            end else if (cmd.splat_issue) begin
                n_reg <= n_reg + NW'(1);
            end
            if (cmd.clear) begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg[0] <= issue_addr;
        dig_reg[0]  <= n_reg;
        w_reg[0]    <= w_next[0];
        for (int k = 1; k < ST; k++) begin
            addr_reg[k] <= addr_reg[k-1];
            dig_reg[k]  <= dig_reg[k-1];
            w_reg[k]    <= w_next[k];
        end
    end

    // Reads run one stage ahead of the write, so data meets the final weight.
    assign rd_addr = (|act_reg) ? addr_reg[ST-2] : cell_addr;
    assign upd_sum = {1'b0, (hist_fg_reg ? fg_rd_reg : bg_rd_reg)} + {16'd0, w_reg[ST-1]};
    assign upd     = upd_sum[32] ? 32'hFFFF_FFFF : upd_sum[31:0];

    always_ff @(posedge aclk) begin
        fg_rd_reg <= fg_mem[rd_addr];
        bg_rd_reg <= bg_mem[rd_addr];
        if (cmd.clear) begin
            fg_mem[clr_reg] <= '0;
            bg_mem[clr_reg] <= '0;
        end else if (act_reg[ST-1]) begin
            if (hist_fg_reg) begin
                fg_mem[addr_reg[ST-1]] <= upd;
            end else begin
                bg_mem[addr_reg[ST-1]] <= upd;
            end
        end
    end

    assign sum      = {1'b0, fg_rd_reg} + {1'b0, bg_rd_reg};
    assign diff     = (fg_rd_reg > bg_rd_reg) ? (fg_rd_reg - bg_rd_reg) : (bg_rd_reg - fg_rd_reg);
    assign den_conf = {1'b0, sum} + lhs_pkg::EP_Q16;
    assign div_num  = cmd.div_sel ? diff : fg_rd_reg;
    assign div_den  = cmd.div_sel ? den_conf : {1'b0, sum};

    lhs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.res_empty) begin
            prob_reg  <= '0;
            conf_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            if (cmd.store_prob) begin
                prob_reg  <= quot;
                empty_reg <= 1'b0;
            end
            if (cmd.store_conf) begin
                conf_reg <= quot;
            end
        end
        if (cmd.load_out) begin
            out_prob_reg  <= prob_reg;
            out_conf_reg  <= conf_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign m_fg_probability = out_prob_reg;
    assign m_confidence     = out_conf_reg;
    assign m_cell_empty     = out_empty_reg;

    assign stat.clr_last   = (clr_reg == {AW{1'b1}});
    assign stat.issue_last = (n_reg == {NW{1'b1}});
    assign stat.pipe_busy  = |act_reg;
    assign stat.cell_empty = (sum == 33'd0);
    assign stat.div_done   = div_done;
    assign stat.div_busy   = div_busy;

endmodule

// File: sv/lhs_ctrl.sv
// ----------------------------------------------------------------------------
// lhs_ctrl
// Controller: memory clear, splat sequencing, query steps, output handshake.
// ----------------------------------------------------------------------------
module lhs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [1:0]     s_action,
    input  logic           m_ready,
    input  lhs_pkg::stat_t stat,
    output lhs_pkg::cmd_t  cmd,
    output logic           s_ready,
    output logic           m_valid
);

    lhs_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lhs_pkg::ST_CLEAR: begin
                if (stat.clr_last) state_next = lhs_pkg::ST_IDLE;
            end
            lhs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == lhs_pkg::ACT_BG || s_action == lhs_pkg::ACT_FG) begin
                        state_next = lhs_pkg::ST_SPLAT;
                    end else if (s_action == lhs_pkg::ACT_QUERY) begin
                        state_next = lhs_pkg::ST_QREAD;
                    end
                end
            end
            lhs_pkg::ST_SPLAT: begin
                if (stat.issue_last) state_next = lhs_pkg::ST_DRAIN;
            end
            lhs_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) state_next = lhs_pkg::ST_IDLE;
            end
            lhs_pkg::ST_QREAD: state_next = lhs_pkg::ST_QCHK;
            lhs_pkg::ST_QCHK: begin
                state_next = stat.cell_empty ? lhs_pkg::ST_QOUT : lhs_pkg::ST_QDIV1;
            end
            lhs_pkg::ST_QDIV1: begin
                if (stat.div_done) state_next = lhs_pkg::ST_QDIV2;
            end
            lhs_pkg::ST_QDIV2: begin
                if (stat.div_done) state_next = lhs_pkg::ST_QOUT;
            end
            lhs_pkg::ST_QOUT: begin
                if (out_free) state_next = lhs_pkg::ST_IDLE;
            end
            default: state_next = lhs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            lhs_pkg::ST_CLEAR: cmd.clear = 1'b1;
            lhs_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            lhs_pkg::ST_SPLAT: cmd.splat_issue = 1'b1;
            lhs_pkg::ST_QCHK: begin
                cmd.res_empty = stat.cell_empty;
                cmd.div_start = !stat.cell_empty;
            end
            lhs_pkg::ST_QDIV1: begin
                cmd.store_prob = stat.div_done;
                cmd.div_start  = stat.div_done;
                cmd.div_sel    = 1'b1;
            end
            lhs_pkg::ST_QDIV2: cmd.store_conf = stat.div_done;
            lhs_pkg::ST_QOUT:  cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lhs_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/lattice_histogram_splat_classifier_unit.sv
// ----------------------------------------------------------------------------
// Lattice histogram splat classifier
// Foreground and background splatted histograms over a 5-D lattice.
// ----------------------------------------------------------------------------
// Channel | Handshake         | Payload
// s_      | s_valid, s_ready  | s_action, s_coord_u/l/g/s/e
// m_      | m_valid, m_ready  | m_fg_probability, m_confidence, m_cell_empty
// cfg_    | cfg_wr_en         | cfg_index, cfg_wdata
//
// An add issues 1024 offsets, one a cycle, into a read-add-write pipeline on
// the histogram memory and then waits for the pipeline to drain.
// A query on a non-empty cell runs two 17-step divisions in turn in one divider.
// After reset a clearing pass writes zero to every memory row, one a cycle, over
// 2**(5*clog2(CELLS_PER_AXIS)) rows (32768 for eight cells per axis).
// A stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "lattice_histogram_splat_classifier_unit_defines.svh"

module lattice_histogram_splat_classifier_unit #(
    parameter int CELLS_PER_AXIS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_coord_u,
    input  logic [15:0] s_coord_l,
    input  logic [15:0] s_coord_g,
    input  logic [15:0] s_coord_s,
    input  logic [15:0] s_coord_e,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_fg_probability,
    output logic [15:0] m_confidence,
    output logic        m_cell_empty
);

    lhs_pkg::cmd_t  cmd;
    lhs_pkg::stat_t stat;

    lhs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd),
        .s_ready  (s_ready),
        .m_valid  (m_valid)
    );

    lhs_dp #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_coord_u        (s_coord_u),
        .s_coord_l        (s_coord_l),
        .s_coord_g        (s_coord_g),
        .s_coord_s        (s_coord_s),
        .s_coord_e        (s_coord_e),
        .cmd              (cmd),
        .stat             (stat),
        .m_fg_probability (m_fg_probability),
        .m_confidence     (m_confidence),
        .m_cell_empty     (m_cell_empty)
    );

    // No new transfer while histogram writes or a division are in flight.
    `LHS_ASSERT_NOW(a_no_accept_in_splat, stat.pipe_busy, !s_ready)
    `LHS_ASSERT_NOW(a_no_accept_in_div, stat.div_busy, !s_ready)
    `LHS_ASSERT_NEXT(a_query_holds_input, s_valid && s_ready && s_action == lhs_pkg::ACT_QUERY, !s_ready)

endmodule

// File: verif/lattice_histogram_splat_classifier_unit_test.sv
// ----------------------------------------------------------------------------
// Lattice histogram splat classifier testbench
// Drives adds and queries through the valid/ready channels and keeps its own
// copy of both histograms. Each query result is checked against the cell
// ratios worked out here. The weight registers change between phases.
// ----------------------------------------------------------------------------
module lattice_histogram_splat_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPA = 8;
    localparam int NCELLS = CPA ** 5;
    localparam int SETTLE_CYCLES = 1200;

    typedef struct packed {
        logic [15:0] prob;
        logic [15:0] conf;
        logic        empty;
    } cell_answer_t;

    class histogram_scoreboard;
        logic [31:0] fg_hist [NCELLS];
        logic [31:0] bg_hist [NCELLS];
        logic [15:0] w_one;
        logic [15:0] w_four;
        cell_answer_t answers [$];
        int mismatches;

        function new();
            foreach (fg_hist[i]) begin
                fg_hist[i] = '0;
                bg_hist[i] = '0;
            end
            w_one = lhs_pkg::WEIGHT_ONE_RESET;
            w_four = lhs_pkg::WEIGHT_FOUR_RESET;
            mismatches = 0;
        endfunction

        function int cell_of(logic [15:0] coord);
            int c;
            c = int'(({16'd0, coord} * 32'(CPA) + 32'd32768) >> 16);
            return (c > CPA - 1) ? CPA - 1 : c;
        endfunction

        function logic [15:0] q16_div(logic [63:0] num, logic [63:0] den);
            logic [63:0] r;
            r = ((num << 16) + den / 2) / den;
            return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
        endfunction

        function void note_item(logic [1:0] act, logic [15:0] crd [5]);
            int cidx [5];
            int id, pos, off, idx;
            logic [63:0] w, f, b, sum, diff;
            logic ok;
            cell_answer_t ans;
            for (int k = 0; k < 5; k++) cidx[k] = cell_of(crd[k]);
            if (act == lhs_pkg::ACT_BG || act == lhs_pkg::ACT_FG) begin
                for (int n = 0; n < 1024; n++) begin
                    w = 64'd65536;
                    idx = 0;
                    ok = 1'b1;
                    for (int k = 0; k < 5; k++) begin
                        off = int'((n >> (2 * (4 - k))) & 3) - 2;
                        pos = cidx[k] + off;
                        if (pos < 0 || pos >= CPA) ok = 1'b0;
                        idx = idx * CPA + pos;
                        if (off == -2) w = (w * w_four + 64'd32768) >> 16;
                        else if (off != 0) w = (w * w_one + 64'd32768) >> 16;
                    end
                    if (ok) begin
                        if (act == lhs_pkg::ACT_FG) begin
                            sum = {32'd0, fg_hist[idx]} + w;
                            fg_hist[idx] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
                        end else begin
                            sum = {32'd0, bg_hist[idx]} + w;
                            bg_hist[idx] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
                        end
                    end
                end
            end else if (act == lhs_pkg::ACT_QUERY) begin
                id = 0;
                for (int k = 0; k < 5; k++) id = id * CPA + cidx[k];
                f = {32'd0, fg_hist[id]};
                b = {32'd0, bg_hist[id]};
                sum = f + b;
                if (sum == 0) begin
                    ans = '{prob: 16'd0, conf: 16'd0, empty: 1'b1};
                end else begin
                    diff = (f > b) ? f - b : b - f;
                    ans.prob = q16_div(f, sum);
                    ans.conf = q16_div(diff, sum + 64'(lhs_pkg::EP_Q16));
                    ans.empty = 1'b0;
                end
                answers.push_back(ans);
            end
        endfunction

        function void check_answer(logic [15:0] prob, logic [15:0] conf, logic empty);
            cell_answer_t exp_ans;
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result prob=%0d conf=%0d empty=%0b", prob, conf, empty);
                return;
            end
            exp_ans = answers.pop_front();
            if (prob !== exp_ans.prob || conf !== exp_ans.conf || empty !== exp_ans.empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected prob=%0d conf=%0d empty=%0b,",
                              " got prob=%0d conf=%0d empty=%0b"},
                             exp_ans.prob, exp_ans.conf, exp_ans.empty, prob, conf, empty);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [15:0] s_coord_u, s_coord_l, s_coord_g, s_coord_s, s_coord_e;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_fg_probability;
    logic [15:0] m_confidence;
    logic        m_cell_empty;

    histogram_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int pool [6][5];

    lattice_histogram_splat_classifier_unit #(.CELLS_PER_AXIS(CPA)) dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = lhs_pkg::REG_WEIGHT_ONE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_action = lhs_pkg::ACT_BG;
        {s_coord_u, s_coord_l, s_coord_g, s_coord_s, s_coord_e} = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
    end

    // Results are taken on the values seen just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_answer(m_fg_probability, m_confidence, m_cell_empty);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(logic [1:0] act, logic [15:0] u, logic [15:0] l,
                             logic [15:0] g, logic [15:0] s, logic [15:0] e);
        logic [15:0] crd [5];
        crd = '{u, l, g, s, e};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        {s_coord_u, s_coord_l, s_coord_g, s_coord_s, s_coord_e} <= {u, l, g, s, e};
        do @(posedge aclk); while (!s_ready);
        sb.note_item(act, crd);
    endtask

    task automatic write_weight(logic idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lhs_pkg::REG_WEIGHT_ONE) sb.w_one = value;
        else sb.w_four = value;
    endtask

    // Adds give no result, so the block may still be splatting after the
    // last query answer has been taken.
    task automatic drain;
        s_valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] coord_near(int c);
        int v;
        v = c * 8192 + int'($urandom_range(8191)) - 4096;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic random_phase(int count);
        logic [1:0] act;
        int p, c;
        logic [15:0] crd [5];
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(5);
            c = $urandom_range(99);
            if (c < 10) begin
                act = 2'($urandom_range(3));
                for (int k = 0; k < 5; k++) crd[k] = 16'($urandom_range(65535));
            end else begin
                act = (c < 50) ? (($urandom_range(1) == 1) ? lhs_pkg::ACT_FG : lhs_pkg::ACT_BG)
                               : lhs_pkg::ACT_QUERY;
                if (c >= 95) act = lhs_pkg::ACT_UNDEFINED;
                for (int k = 0; k < 5; k++) begin
                    int cc;
                    cc = pool[p][k];
                    if (act == lhs_pkg::ACT_QUERY) cc = cc + int'($urandom_range(3)) - 2;
                    if (cc < 0) cc = 0;
                    if (cc > CPA - 1) cc = CPA - 1;
                    crd[k] = coord_near(cc);
                end
            end
            send_item(act, crd[0], crd[1], crd[2], crd[3], crd[4]);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 6; p++)
            for (int k = 0; k < 5; k++) pool[p][k] = $urandom_range(CPA - 1);

        write_weight(lhs_pkg::REG_WEIGHT_ONE, lhs_pkg::WEIGHT_ONE_RESET);
        write_weight(lhs_pkg::REG_WEIGHT_FOUR, lhs_pkg::WEIGHT_FOUR_RESET);

        // Directed: empty cells, extremes, rounding edges, ignored action.
        send_item(lhs_pkg::ACT_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(lhs_pkg::ACT_FG, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_BG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(lhs_pkg::ACT_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(lhs_pkg::ACT_QUERY, 16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'd4095);
        send_item(lhs_pkg::ACT_QUERY, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_UNDEFINED, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_QUERY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(lhs_pkg::ACT_BG, 16'd20480, 16'd20480, 16'd20480, 16'd20480, 16'd20480);
        send_item(lhs_pkg::ACT_FG, 16'd28672, 16'd28672, 16'd28672, 16'd28672, 16'd28672);
        send_item(lhs_pkg::ACT_QUERY, 16'd20480, 16'd20480, 16'd20480, 16'd20480, 16'd20480);
        send_item(lhs_pkg::ACT_QUERY, 16'd24576, 16'd24576, 16'd24576, 16'd24576, 16'd24576);
        send_item(lhs_pkg::ACT_QUERY, 16'd28672, 16'd28672, 16'd28672, 16'd28672, 16'd28672);
        send_item(lhs_pkg::ACT_QUERY, 16'd57344, 16'd61439, 16'd61440, 16'd0, 16'd65535);
        drain();

        send_idle_pct = 16;
        recv_idle_pct = 72;
        write_weight(lhs_pkg::REG_WEIGHT_ONE, 16'd0);
        write_weight(lhs_pkg::REG_WEIGHT_FOUR, 16'hFFFF);
        random_phase(190);
        drain();

        send_idle_pct = 72;
        recv_idle_pct = 16;
        write_weight(lhs_pkg::REG_WEIGHT_ONE, 16'hFFFF);
        write_weight(lhs_pkg::REG_WEIGHT_FOUR, 16'd0);
        random_phase(190);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_weight(lhs_pkg::REG_WEIGHT_ONE, 16'($urandom_range(65535)));
        write_weight(lhs_pkg::REG_WEIGHT_FOUR, 16'($urandom_range(65535)));
        random_phase(190);
        drain();

        if (sb.mismatches == 0 && sb.answers.size() == 0) begin
            $display("[lattice_histogram_splat_classifier_unit] OK");
        end else begin
            $display("[lattice_histogram_splat_classifier_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("[lattice_histogram_splat_classifier_unit] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/lhs_pkg.sv
sv/lhs_div.sv
sv/lhs_dp.sv
sv/lhs_ctrl.sv
sv/lattice_histogram_splat_classifier_unit.sv
verif/lattice_histogram_splat_classifier_unit_test.sv
